[hw/rtl/rotor_byte_cipher_unit_macros.svh]
// Assertion macros shared by the rotor cipher RTL.
`ifndef ROTOR_BYTE_CIPHER_UNIT_MACROS_SVH
`define ROTOR_BYTE_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotor cipher check failed");

// Next-cycle implication, checked outside reset.
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotor cipher check failed");

`endif

[hw/rtl/rbc_pkg.sv]
`default_nettype none

package rbc_pkg;

  localparam int SYM_W         = 8;
  localparam int ALPHABET_SIZE = 1 << SYM_W;
  localparam int NUM_ROTORS    = 3;
  localparam int SEL_W         = 2;
  localparam int ACT_W         = 2;
  // forward pass through each rotor, reflector, inverse pass through each rotor
  localparam int NUM_LOOKUPS   = 2 * NUM_ROTORS + 1;
  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENCODE     = 2'd0,
    ACT_LOAD_ROTOR = 2'd1,
    ACT_LOAD_REFL  = 2'd2,
    ACT_RESTART    = 2'd3
  } action_t;

  typedef logic [SYM_W-1:0] sym_t;
  typedef sym_t [NUM_ROTORS-1:0] offs_t;

  typedef struct packed {
    action_t           action;
    logic [SEL_W-1:0]  sel;
    sym_t              idx;
    sym_t              val;
    offs_t             offs;
  } item_t;

  typedef struct packed {
    logic step;
    logic clear;
  } offs_ctrl_t;

  typedef struct packed {
    logic valid;
    sym_t cipher;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/rbc_ram.sv]
`default_nettype none

module rbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rbc_offsets.sv]
`default_nettype none

module rbc_offsets (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rbc_pkg::offs_ctrl_t ctrl,
  output      rbc_pkg::offs_t     offs
);

  rbc_pkg::offs_t                offs_next;
  logic [rbc_pkg::NUM_ROTORS:0]  carry;

  // odometer: each rotor steps when every rotor below it wraps
  always_comb begin
    carry[0] = ctrl.step;
    for (int r = 0; r < rbc_pkg::NUM_ROTORS; r++) begin
      offs_next[r] = offs[r] + rbc_pkg::SYM_W'(carry[r]);
      carry[r+1]   = carry[r] && (offs[r] == '1);
    end
    if (ctrl.clear) begin
      offs_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offs <= '0;
    end else begin
      offs <= offs_next;
    end
  end

`include "rotor_byte_cipher_unit_macros.svh"

  `RBC_ASSERT_NEXT(a_clear_zeroes, clk, rst, ctrl.clear, offs == '0)
  `RBC_ASSERT_NEXT(a_first_steps, clk, rst, ctrl.step && !ctrl.clear,
                   offs[0] == $past(offs[0]) + rbc_pkg::SYM_W'(1))

endmodule

`default_nettype wire

[hw/rtl/rbc_lookup_pipe.sv]
`default_nettype none

module rbc_lookup_pipe (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire rbc_pkg::item_t in_item,
  output      rbc_pkg::res_t res
);

  localparam int N  = rbc_pkg::NUM_ROTORS;
  localparam int NL = rbc_pkg::NUM_LOOKUPS;

  rbc_pkg::item_t st    [0:NL];
  logic           vld   [0:NL];
  rbc_pkg::sym_t  rdata [0:NL-1];
  rbc_pkg::sym_t  sym   [0:NL];

  // Each item moves one stage per advance. Loads write their table at the
  // stage that reads it, so table order follows request order.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NL; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 0; k < NL; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= in_item;
      for (int k = 0; k < NL; k++) begin
        st[k+1] <= st[k];
      end
    end
  end

  assign sym[0] = st[0].val;

  for (genvar j = 0; j < NL; j++) begin : g_lookup
    rbc_pkg::sym_t raddr;
    rbc_pkg::sym_t waddr;
    rbc_pkg::sym_t wdata;
    logic          we;

    if (j < N) begin : g_fwd
      assign raddr = sym[j] - st[j].offs[j];
      assign we    = adv && vld[j] && (st[j].action == rbc_pkg::ACT_LOAD_ROTOR)
                     && (st[j].sel == rbc_pkg::SEL_W'(j));
      assign waddr = st[j].idx;
      assign wdata = st[j].val;
      assign sym[j+1] = rdata[j];
    end else if (j == N) begin : g_refl
      assign raddr = sym[j];
      assign we    = adv && vld[j] && (st[j].action == rbc_pkg::ACT_LOAD_REFL);
      assign waddr = st[j].idx;
      assign wdata = st[j].val;
      assign sym[j+1] = rdata[j];
    end else begin : g_inv
      localparam int R = 2 * N - j;
      assign raddr = sym[j];
      assign we    = adv && vld[j] && (st[j].action == rbc_pkg::ACT_LOAD_ROTOR)
                     && (st[j].sel == rbc_pkg::SEL_W'(R));
      assign waddr = st[j].val;
      assign wdata = st[j].idx;
      // undo the rotor turn on the way back
      assign sym[j+1] = rdata[j] + st[j+1].offs[R];
    end

    rbc_ram #(
      .WIDTH(rbc_pkg::SYM_W),
      .DEPTH(rbc_pkg::ALPHABET_SIZE)
    ) u_table (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (adv),
      .raddr(raddr),
      .rdata(rdata[j])
    );
  end

  assign res.valid  = vld[NL] && (st[NL].action == rbc_pkg::ACT_ENCODE);
  assign res.cipher = sym[NL];

endmodule

`default_nettype wire

[hw/rtl/rbc_result_buf.sv]
`default_nettype none

module rbc_result_buf (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire rbc_pkg::sym_t                   din,
  output      logic                            space,
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  output      logic [rbc_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam logic [1:0] FULL = 2'd2;

  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  rbc_pkg::sym_t d0;
  rbc_pkg::sym_t d1;
  logic          pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign space    = (cnt != FULL);
  assign m_tdata  = d0;

  always_comb begin
    cnt_next = cnt + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // d0 is the head; d1 holds a second result while the receiver stalls
  always_ff @(posedge clk) begin
    if (push && ((cnt == 2'd0) || ((cnt == 2'd1) && pop))) begin
      d0 <= din;
    end else if (pop && (cnt == FULL)) begin
      d0 <= d1;
    end
    if (push && (cnt == 2'd1) && !pop) begin
      d1 <= din;
    end
  end

`include "rotor_byte_cipher_unit_macros.svh"

  `RBC_ASSERT_IMPL(a_no_overflow, clk, rst, push, cnt != FULL)
  `RBC_ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, cnt == $past(cnt) + 2'd1)

endmodule

`default_nettype wire

[hw/rtl/rotor_byte_cipher_unit.sv]
// Three-rotor byte substitution cipher with a reflector.
// Input stream (s_*): one request per accepted beat. s_tuser carries the action:
// encode a byte, load one rotor entry (which fills the inverse entry too), load
// one reflector entry, or restart all rotor positions at zero.
// Output stream (m_*): one cipher byte for each encode request, in request order;
// load and restart requests give no output.
// Throughput: one request per cycle while s_tready is high. Each request walks a
// seven-stage table pipeline (three rotors forward, reflector, three rotors
// backward), one table RAM read per stage, before its cipher byte enters the
// result buffer.
// Rotor positions step when an encode request is accepted, so back-to-back
// requests each see their own rotor setting.
// Reset clears the rotor positions, the pipeline and the result buffer; table
// contents are kept and must be loaded before use.
// When the receiver stalls, a two-entry result buffer absorbs output; once it
// is full the pipeline holds and s_tready drops until a result is taken.
`default_nettype none

module rotor_byte_cipher_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // [1:0] rotor_select, [9:2] entry_index, [17:10] data_value, [23:18] zero
  input  wire logic [rbc_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] action
  input  wire logic [rbc_pkg::ACT_W-1:0]     s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // [7:0] cipher_byte
  output      logic [rbc_pkg::M_TDATA_W-1:0] m_tdata
);

  logic                accept;
  logic                adv;
  rbc_pkg::action_t    action;
  rbc_pkg::offs_t      offs;
  rbc_pkg::offs_ctrl_t offs_ctrl;
  rbc_pkg::item_t      in_item;
  rbc_pkg::res_t       res;
  logic                space;

  assign action   = rbc_pkg::action_t'(s_tuser);
  assign adv      = space;
  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  assign offs_ctrl.step  = accept && (action == rbc_pkg::ACT_ENCODE);
  assign offs_ctrl.clear = accept && (action == rbc_pkg::ACT_RESTART);

  assign in_item.action = action;
  assign in_item.sel    = s_tdata[rbc_pkg::SEL_W-1:0];
  assign in_item.idx    = s_tdata[rbc_pkg::SEL_W +: rbc_pkg::SYM_W];
  assign in_item.val    = s_tdata[rbc_pkg::SEL_W + rbc_pkg::SYM_W +: rbc_pkg::SYM_W];
  assign in_item.offs   = offs;

  rbc_offsets u_offsets (
    .clk (clk),
    .rst (rst),
    .ctrl(offs_ctrl),
    .offs(offs)
  );

  rbc_lookup_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_valid(accept),
    .in_item (in_item),
    .res     (res)
  );

  rbc_result_buf u_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (adv && res.valid),
    .din     (res.cipher),
    .space   (space),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

`default_nettype wire
